[hdl/psu_pkg.sv]
package psu_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STRIDE_W = 4;
    localparam int unsigned ROWLEN_W = 14;
    localparam int unsigned CFG_W    = 14;
    localparam int unsigned CFG_IX_W = 1;
    localparam int unsigned TYPE_W   = 3;
    localparam int unsigned TUSER_W  = 4;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_PIXEL_STRIDE = 1'b0,
        CFG_ROW_BYTES    = 1'b1
    } t_cfg_ix;

    typedef enum logic [TYPE_W-1:0] {
        FLT_NONE    = 3'd0,
        FLT_SUB     = 3'd1,
        FLT_UP      = 3'd2,
        FLT_AVERAGE = 3'd3,
        FLT_PAETH   = 3'd4
    } t_filter;

    function automatic logic [BYTE_W-1:0] paeth(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic signed [BYTE_W+1:0] sa;
        logic signed [BYTE_W+1:0] sb;
        logic signed [BYTE_W+1:0] sc;
        logic signed [BYTE_W+1:0] da;
        logic signed [BYTE_W+1:0] db;
        logic signed [BYTE_W+1:0] dc;
        logic [BYTE_W+1:0] pa;
        logic [BYTE_W+1:0] pb;
        logic [BYTE_W+1:0] pc;
        sa = $signed({2'b00, a});
        sb = $signed({2'b00, b});
        sc = $signed({2'b00, c});
        da = sb - sc;
        db = sa - sc;
        dc = sa + sb - sc - sc;
        pa = da[BYTE_W+1] ? $unsigned(-da) : $unsigned(da);
        pb = db[BYTE_W+1] ? $unsigned(-db) : $unsigned(db);
        pc = dc[BYTE_W+1] ? $unsigned(-dc) : $unsigned(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

endpackage

[hdl/psu_ram.sv]
module psu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/png_scanline_unfilter.sv]
// PNG scanline unfilter: one filtered byte in, one reconstructed byte out.
// One byte per cycle unless the output stalls; the left-byte recurrence closes in-stage.
// The result passes the reconstruct stage and the output register (two register stages).
// Line store read is registered; a same-address write at the read edge is forwarded.
// Reset (synchronous, active low) clears position, histories and pipe valids and sets
// stride and row length to 1; the line store is not cleared and needs no clearing pass.
module png_scanline_unfilter #(
    parameter int unsigned MAX_ROW_BYTES = 8192,
    parameter int unsigned MAX_STRIDE    = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [psu_pkg::CFG_IX_W-1:0]   i_cfg_addr,
    input  logic [psu_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [psu_pkg::BYTE_W-1:0]     s_axis_tdata,  // [7:0] filtered_byte
    input  logic [psu_pkg::TUSER_W-1:0]    s_axis_tuser,  // [2:0] filter_type, [3] no_prev_row
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [psu_pkg::BYTE_W-1:0]     m_axis_tdata,  // [7:0] recon_byte
    output logic                           m_axis_tlast   // last_in_row
);

    localparam int unsigned PW = $clog2(MAX_ROW_BYTES);
    localparam int unsigned LW = (PW + 1 > psu_pkg::ROWLEN_W) ? PW + 1 : psu_pkg::ROWLEN_W;
    localparam int unsigned SW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;

    logic [psu_pkg::STRIDE_W-1:0] r_stride;
    logic [psu_pkg::ROWLEN_W-1:0] r_row_bytes;

    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;

    logic                        r_s1_valid;
    logic [PW-1:0]               r_s1_pos;
    logic                        r_s1_last;
    logic                        r_s1_has_left;
    logic [SW-1:0]               r_s1_sidx;
    logic [psu_pkg::BYTE_W-1:0]  r_s1_byte;
    logic [psu_pkg::TYPE_W-1:0]  r_s1_type;
    logic                        r_s1_noprev;

    logic                        r_fwd_hit;
    logic [psu_pkg::BYTE_W-1:0]  r_fwd_data;

    logic                        r_out_valid;
    logic [psu_pkg::BYTE_W-1:0]  r_out_data;
    logic                        r_out_last;

    logic [psu_pkg::BYTE_W-1:0]  r_left   [MAX_STRIDE];
    logic [psu_pkg::BYTE_W-1:0]  r_upleft [MAX_STRIDE];

    logic                        in_accept;
    logic                        s1_adv;
    logic [psu_pkg::STRIDE_W-1:0] stride_eff;
    logic [LW-1:0]               rb_eff;
    logic                        n_last;
    logic                        n_has_left;
    logic [psu_pkg::BYTE_W-1:0]  ram_rdata;
    logic [psu_pkg::BYTE_W-1:0]  line_b;
    logic [psu_pkg::BYTE_W-1:0]  a_val;
    logic [psu_pkg::BYTE_W-1:0]  b_val;
    logic [psu_pkg::BYTE_W-1:0]  c_val;
    logic [psu_pkg::BYTE_W:0]    ab_sum;
    logic [psu_pkg::BYTE_W-1:0]  pred;
    logic [psu_pkg::BYTE_W-1:0]  recon;

    // Effective configuration
    always_comb begin
        stride_eff = r_stride;
        if (stride_eff == '0) begin
            stride_eff = psu_pkg::STRIDE_W'(1);
        end else if (stride_eff > psu_pkg::STRIDE_W'(MAX_STRIDE)) begin
            stride_eff = psu_pkg::STRIDE_W'(MAX_STRIDE);
        end
        rb_eff = LW'(r_row_bytes);
        if (rb_eff == '0) begin
            rb_eff = LW'(1);
        end else if (rb_eff > LW'(MAX_ROW_BYTES)) begin
            rb_eff = LW'(MAX_ROW_BYTES);
        end
    end

    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign n_last     = (LW'(r_pos) + LW'(1)) >= rb_eff;
    assign n_has_left = r_pos >= PW'(stride_eff);
    assign n_pos      = n_last ? '0 : r_pos + PW'(1);

    psu_ram #(
        .WIDTH (psu_pkg::BYTE_W),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_pos),
        .i_wdata (recon),
        .i_re    (in_accept),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    // Reconstruct
    always_comb begin
        line_b = r_fwd_hit ? r_fwd_data : ram_rdata;
        b_val  = r_s1_noprev ? '0 : line_b;
        a_val  = r_s1_has_left ? r_left[r_s1_sidx] : '0;
        c_val  = (r_s1_has_left && !r_s1_noprev) ? r_upleft[r_s1_sidx] : '0;
        ab_sum = {1'b0, a_val} + {1'b0, b_val};
        case (r_s1_type)
            psu_pkg::FLT_SUB:     pred = a_val;
            psu_pkg::FLT_UP:      pred = b_val;
            psu_pkg::FLT_AVERAGE: pred = ab_sum[psu_pkg::BYTE_W:1];
            psu_pkg::FLT_PAETH:   pred = psu_pkg::paeth(a_val, b_val, c_val);
            default:              pred = '0;
        endcase
        recon = r_s1_byte + pred;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride    <= psu_pkg::STRIDE_W'(1);
            r_row_bytes <= psu_pkg::ROWLEN_W'(1);
            r_pos       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
            for (int i = 0; i < MAX_STRIDE; i++) begin
                r_left[i]   <= '0;
                r_upleft[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (psu_pkg::t_cfg_ix'(i_cfg_addr))
                    psu_pkg::CFG_PIXEL_STRIDE:
                        r_stride <= i_cfg_wdata[psu_pkg::STRIDE_W-1:0];
                    psu_pkg::CFG_ROW_BYTES:
                        r_row_bytes <= i_cfg_wdata[psu_pkg::ROWLEN_W-1:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_pos      <= n_pos;
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= s1_adv && (r_s1_pos == r_pos);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                for (int i = MAX_STRIDE - 1; i > 0; i--) begin
                    r_left[i]   <= r_left[i-1];
                    r_upleft[i] <= r_upleft[i-1];
                end
                r_left[0]   <= recon;
                r_upleft[0] <= b_val;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pos      <= r_pos;
            r_s1_last     <= n_last;
            r_s1_has_left <= n_has_left;
            r_s1_sidx     <= SW'(stride_eff - psu_pkg::STRIDE_W'(1));
            r_s1_byte     <= s_axis_tdata;
            r_s1_type     <= s_axis_tuser[psu_pkg::TYPE_W-1:0];
            r_s1_noprev   <= s_axis_tuser[psu_pkg::TYPE_W];
            r_fwd_data    <= recon;
        end
        if (s1_adv) begin
            r_out_data <= recon;
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_fwd_on_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && s1_adv && (r_s1_pos == r_pos)) |=> r_fwd_hit)
        else $error("line store collision not forwarded");

    a_hold_stalled_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_pos)))
        else $error("stalled request lost in reconstruct stage");

    a_wrap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_last) |=> (r_pos == '0))
        else $error("position did not wrap after row end");
`endif

endmodule
